// File: src/fdot_pkg.sv
package fdot_pkg;

  localparam int LANES_DEF = 12;
  localparam int HALF_W    = 16;
  localparam int SUM_W     = 32;
  localparam int IDX_OUT_W = 4;
  localparam int IN_W      = 208;
  localparam int OUT_W     = 40;

  localparam logic [SUM_W-1:0] CANON_NAN = 32'h7FC0_0000;

  // sequencer steps of one item
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ADD  = 4'b0100,
    S_WB   = 4'b1000
  } step_t;

  // lockstep controls shared by all lanes
  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic wb_en;
    logic last;
  } fdot_ctrl_t;

  // exact binary16 -> binary32 widening
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] p;
    logic [22:0] fr;
    logic [31:0] r;
    s  = h[15];
    e  = h[14:10];
    m  = h[9:0];
    p  = 4'd0;
    fr = 23'd0;
    for (int k = 0; k < 10; k++) begin
      if (m[k]) p = 4'(k);
    end
    if (e == 5'd31) begin
      r = {s, 8'hFF, m, 13'd0};
    end else if (e == 5'd0) begin
      if (m == 10'd0) begin
        r = {s, 31'd0};
      end else begin
        fr = 23'({13'd0, m} << (5'd23 - {1'b0, p}));
        r  = {s, 8'd103 + {4'd0, p}, fr};
      end
    end else begin
      r = {s, {3'd0, e} + 8'd112, m, 13'd0};
    end
    return r;
  endfunction

endpackage

// File: src/fdot_lane.sv
module fdot_lane
  import fdot_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [HALF_W-1:0]   query,
  input  logic [HALF_W-1:0]   cand,
  input  fdot_ctrl_t          ctrl,
  output logic [SUM_W-1:0]    res
);

  logic [31:0] qf, cf;
  logic [31:0] prod, prod_next;
  logic [31:0] acc, acc_next;
  logic [21:0] pm;
  logic [9:0]  pe;
  logic        ps;
  logic        qz, cz, qi, ci, qn, cn;

  assign qf = half_to_single(query);
  assign cf = half_to_single(cand);

  // exact product; finite nonzero products are normal binary32 values
  always_comb begin
    ps = qf[31] ^ cf[31];
    qz = (qf[30:0] == 31'd0);
    cz = (cf[30:0] == 31'd0);
    qi = (qf[30:23] == 8'hFF) && (qf[22:0] == 23'd0);
    ci = (cf[30:23] == 8'hFF) && (cf[22:0] == 23'd0);
    qn = (qf[30:23] == 8'hFF) && (qf[22:0] != 23'd0);
    cn = (cf[30:23] == 8'hFF) && (cf[22:0] != 23'd0);
    pm = {1'b1, qf[22:13]} * {1'b1, cf[22:13]};
    pe = {2'd0, qf[30:23]} + {2'd0, cf[30:23]} - 10'd127 + {9'd0, pm[21]};
    if (qn || cn || (qi && cz) || (ci && qz)) begin
      prod_next = CANON_NAN;
    end else if (qi || ci) begin
      prod_next = {ps, 8'hFF, 23'd0};
    end else if (qz || cz) begin
      prod_next = {ps, 31'd0};
    end else if (pm[21]) begin
      prod_next = {ps, pe[7:0], pm[20:0], 2'd0};
    end else begin
      prod_next = {ps, pe[7:0], pm[19:0], 3'd0};
    end
  end

  // adder step one: order, align, add
  logic        swap;
  logic [31:0] xv, yv;
  logic [7:0]  xe, ye, d;
  logic [26:0] xs, ys, ys_sh, mask;
  logic        stk;
  logic [27:0] sum_next;
  logic        a_n, b_n, a_i, b_i;
  logic        spec_next;
  logic [31:0] spec_val_next;

  logic [27:0] s1_sum;
  logic [7:0]  s1_exp;
  logic        s1_sign, s1_zsign, s1_spec;
  logic [31:0] s1_spec_val;

  always_comb begin
    swap  = (prod[30:0] > acc[30:0]);
    xv    = swap ? prod : acc;
    yv    = swap ? acc : prod;
    xe    = (xv[30:23] == 8'd0) ? 8'd1 : xv[30:23];
    ye    = (yv[30:23] == 8'd0) ? 8'd1 : yv[30:23];
    xs    = {(xv[30:23] != 8'd0), xv[22:0], 3'd0};
    ys    = {(yv[30:23] != 8'd0), yv[22:0], 3'd0};
    d     = xe - ye;
    mask  = 27'd0;
    ys_sh = 27'd0;
    if (d >= 8'd27) begin
      stk = |ys;
    end else begin
      mask  = (27'd1 << d[4:0]) - 27'd1;
      ys_sh = ys >> d[4:0];
      stk   = |(ys & mask);
    end
    if (xv[31] ^ yv[31]) begin
      sum_next = {1'b0, xs} - {1'b0, ys_sh[26:1], ys_sh[0] | stk};
    end else begin
      sum_next = {1'b0, xs} + {1'b0, ys_sh[26:1], ys_sh[0] | stk};
    end
    a_n = (acc[30:23] == 8'hFF) && (acc[22:0] != 23'd0);
    b_n = (prod[30:23] == 8'hFF) && (prod[22:0] != 23'd0);
    a_i = (acc[30:23] == 8'hFF) && (acc[22:0] == 23'd0);
    b_i = (prod[30:23] == 8'hFF) && (prod[22:0] == 23'd0);
    spec_next     = a_n || b_n || a_i || b_i;
    spec_val_next = CANON_NAN;
    if (!(a_n || b_n || (a_i && b_i && (acc[31] != prod[31])))) begin
      spec_val_next = a_i ? acc : prod;
    end
  end

  // adder step two: normalise and round to nearest even
  logic [4:0]  lz;
  logic        found;
  logic [7:0]  sh;
  logic [26:0] sn;
  logic [8:0]  en;
  logic [30:0] rounded;
  logic        rnd;
  logic [31:0] result;

  always_comb begin
    lz    = 5'd27;
    found = 1'b0;
    for (int k = 26; k >= 0; k--) begin
      if (!found && s1_sum[k]) begin
        lz    = 5'(26 - k);
        found = 1'b1;
      end
    end
    sh = ({3'd0, lz} < (s1_exp - 8'd1)) ? {3'd0, lz} : (s1_exp - 8'd1);
    if (s1_sum[27]) begin
      sn = {s1_sum[27:2], s1_sum[1] | s1_sum[0]};
      en = {1'b0, s1_exp} + 9'd1;
    end else begin
      sn = s1_sum[26:0] << sh[4:0];
      en = {1'b0, s1_exp} - {1'b0, sh};
    end
    rnd     = sn[2] & (sn[1] | sn[0] | sn[3]);
    rounded = {(sn[26] ? en[7:0] : 8'd0), sn[25:3]} + {30'd0, rnd};
    if (s1_spec) begin
      result = s1_spec_val;
    end else if (s1_sum == 28'd0) begin
      result = {s1_zsign, 31'd0};
    end else if (en >= 9'd255) begin
      result = {s1_sign, 8'hFF, 23'd0};
    end else begin
      result = {s1_sign, rounded};
    end
    acc_next = (ctrl.wb_en && ctrl.last) ? 32'd0 : (ctrl.wb_en ? result : acc);
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) prod <= prod_next;
    if (ctrl.add_en) begin
      s1_sum      <= sum_next;
      s1_exp      <= xe;
      s1_sign     <= xv[31];
      s1_zsign    <= acc[31] & prod[31];
      s1_spec     <= spec_next;
      s1_spec_val <= spec_val_next;
    end
    if (ctrl.wb_en && ctrl.last) res <= result;
  end

  // accumulator, cleared to positive zero
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 32'd0;
    end else begin
      acc <= acc_next;
    end
  end

endmodule

// File: src/fdot_drain.sv
module fdot_drain
  import fdot_pkg::*;
#(
  parameter int LANES = LANES_DEF
)(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SUM_W-1:0]    sums [LANES],
  output logic                busy,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_W-1:0]    m_tdata,  // lane_index[3:0], lane_sum[35:4], zero pad
  output logic                m_tlast   // last_lane
);

  localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic [IDX_W-1:0] idx;
  logic [IDX_OUT_W-1:0] idx_out;

  assign idx_out  = IDX_OUT_W'(idx);
  assign m_tvalid = busy;
  assign m_tlast  = (idx == IDX_W'(LANES - 1));
  assign m_tdata  = {{(OUT_W - SUM_W - IDX_OUT_W){1'b0}}, sums[idx], idx_out};

  // hand the results out one lane per item
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && m_tready) begin
      if (m_tlast) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

endmodule

// File: src/fp16_batch_dot_fp32_accumulate.sv
// Item handling: each input item passes the accept, multiply, align-add and normalise-round
//   steps before the next is accepted; each lane's accumulator closes a loop through its adder.
// Output: the sums are registered when the last item is written back, then one sum per cycle
//   while m_tready is high; a further last item waits while sums drain.
// Reset (rst, synchronous): accumulators to +0, sequencer idle, no results pending.
module fp16_batch_dot_fp32_accumulate
  import fdot_pkg::*;
#(
  parameter int LANES = LANES_DEF
)(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // query_half[15:0], cand_pack_0..2[207:16]
  input  logic             s_tlast,  // last_element
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // lane_index[3:0], lane_sum[35:4], zero pad
  output logic             m_tlast   // last_lane
);

  step_t           step, step_next;
  logic [IN_W-1:0] item;
  logic            last_r;
  logic            dbusy;
  fdot_ctrl_t      ctrl;
  logic [SUM_W-1:0] sums [LANES];

  assign s_tready = (step == S_IDLE);

  // sequencer
  always_comb begin
    ctrl.mul_en = (step == S_MUL);
    ctrl.add_en = (step == S_ADD);
    ctrl.wb_en  = (step == S_WB) && (!last_r || !dbusy);
    ctrl.last   = last_r;
    unique case (step)
      S_IDLE:  step_next = (s_tvalid && s_tready) ? S_MUL : S_IDLE;
      S_MUL:   step_next = S_ADD;
      S_ADD:   step_next = S_WB;
      S_WB:    step_next = ctrl.wb_en ? S_IDLE : S_WB;
      default: step_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // input item register
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item   <= s_tdata;
      last_r <= s_tlast;
    end
  end

  // lanes
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    fdot_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .query (item[HALF_W-1:0]),
      .cand  (item[HALF_W*(i+1) +: HALF_W]),
      .ctrl  (ctrl),
      .res   (sums[i])
    );
  end

  // result sequencing
  fdot_drain #(.LANES(LANES)) u_drain (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.wb_en && last_r),
    .sums     (sums),
    .busy     (dbusy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
